// ----- hw/rtl/replacement_selection_runs_assert.svh -----
// Assertion macros shared by the RTL of the replacement selection block.
`ifndef REPLACEMENT_SELECTION_RUNS_ASSERT_SVH
`define REPLACEMENT_SELECTION_RUNS_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define RSR_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that holds in the same cycle as its trigger.
`define RSR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition that holds in the cycle after its trigger.
`define RSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/rsr_pkg.sv -----
`timescale 1ns / 1ps

package rsr_pkg;

    localparam int SLOTS  = 8;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FILL_W = $clog2(SLOTS + 1);

    localparam int KEY_W  = 16;
    localparam int PAY_W  = 32;
    localparam int TAPE_W = 6;
    localparam int REC_W  = KEY_W + PAY_W;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 56;

    localparam logic [TAPE_W-1:0] TAPE_COUNT_RESET = 6'd20;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_FLUSH  = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_SCAN  = 5'b00100,
        S_LAST  = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

endpackage

// ----- hw/rtl/replacement_selection_runs.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Fields (tdata / tuser / tlast, lowest bit first)
// s_axis    in   tdata: key[15:0], payload[47:16]; tuser: action
// m_axis    out  tdata: out_key[15:0], out_payload[47:16], tape[53:48], zero[55:54];
//                tuser: run_end; tlast: last_of_item
// cfg       in   i_cfg_data: tape_count (always ready)
//
// An insert that only fills the store leaves the block idle. Any other insert passes through
// accept, run check, a read of every slot of the slot memory, compare of the last read, emission.
// A flush is accepted, then each stored record passes through run check, scan, compare and
// emission, and the drain ends with the final marker. A run-end marker leaves in the run check
// state and adds no state of its own. The slot memory has a single read port, one entry per cycle.
// Reset is synchronous and active low; the slot memory needs no clearing since valid bits
// guard it. A stalled output only holds the block in the state that wants to emit.
`include "replacement_selection_runs_assert.svh"

module replacement_selection_runs
    import rsr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // key, payload
    input  logic [0:0]            s_axis_tuser,   // action

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // out_key, out_payload, tape, zero pad
    output logic [0:0]            m_axis_tuser,   // run_end
    output logic                  m_axis_tlast,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [TAPE_W-1:0]     i_cfg_data
);

    t_state              r_state, n_state;
    logic [SLOTS-1:0]    r_valid, r_locked;
    logic [KEY_W-1:0]    r_last_key;
    logic                r_emitted;
    logic [FILL_W-1:0]   r_fill;
    logic [SLOT_W-1:0]   r_free;
    logic [TAPE_W-1:0]   r_tape, r_tape_count;
    logic                r_flush;

    logic [REC_W-1:0]    r_mem [SLOTS];
    logic [SLOT_W-1:0]   r_rd_addr, r_rd_idx;
    logic [REC_W-1:0]    r_rd_data;
    logic                r_rd_vld;

    logic                r_best_found;
    logic [SLOT_W-1:0]   r_best_idx;
    logic [KEY_W-1:0]    r_best_key;
    logic [PAY_W-1:0]    r_best_pay;

    logic                r_out_valid, r_out_run_end, r_out_last;
    logic [KEY_W-1:0]    r_out_key;
    logic [PAY_W-1:0]    r_out_pay;
    logic [TAPE_W-1:0]   r_out_tape;

    logic                w_in_acc, w_in_flush, w_out_free, w_all_locked, w_cand;
    logic                w_load, w_ld_mark, w_ld_last, w_filling;
    logic [KEY_W-1:0]    w_in_key;
    logic [PAY_W-1:0]    w_in_pay;
    logic [SLOT_W-1:0]   w_ins_slot;
    logic [FILL_W-1:0]   w_fill_inc;
    logic [TAPE_W-1:0]   w_tc, w_next_tape;
    logic [TAPE_W:0]     w_tape_inc;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;

    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_in_flush = (s_axis_tuser[0] == ACT_FLUSH);
    assign w_in_key   = s_axis_tdata[KEY_W-1:0];
    assign w_in_pay   = s_axis_tdata[REC_W-1:KEY_W];

    assign w_out_free   = !r_out_valid || m_axis_tready;
    assign w_all_locked = (r_valid != '0) && ((r_valid & ~r_locked) == '0);

    assign w_filling  = (r_fill < FILL_W'(SLOTS));
    assign w_ins_slot = w_filling ? r_fill[SLOT_W-1:0] : r_free;
    assign w_fill_inc = r_fill + 1'b1;

    // A tape count of zero behaves as one; a tape beyond the count wraps on its next advance.
    assign w_tc        = (r_tape_count == '0) ? TAPE_W'(1) : r_tape_count;
    assign w_tape_inc  = {1'b0, r_tape} + 1'b1;
    assign w_next_tape = (w_tape_inc >= {1'b0, w_tc}) ? '0 : w_tape_inc[TAPE_W-1:0];

    // Compare stage of the scan: lowest index wins among equal keys.
    assign w_cand = r_rd_vld && r_valid[r_rd_idx] && !r_locked[r_rd_idx]
                    && (!r_best_found || (r_rd_data[KEY_W-1:0] < r_best_key));

    always_comb begin
        n_state   = r_state;
        w_load    = 1'b0;
        w_ld_mark = 1'b0;
        w_ld_last = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (w_in_flush) begin
                        n_state = S_CHECK;
                    end else if (!(w_filling && (w_fill_inc < FILL_W'(SLOTS)))) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (r_valid == '0) begin
                    // Only a flush reaches an empty store: the final marker.
                    if (w_out_free) begin
                        w_load    = 1'b1;
                        w_ld_mark = 1'b1;
                        w_ld_last = 1'b1;
                        n_state   = S_IDLE;
                    end
                end else if (w_all_locked) begin
                    if (w_out_free) begin
                        w_load    = 1'b1;
                        w_ld_mark = 1'b1;
                        n_state   = S_SCAN;
                    end
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_rd_addr == SLOT_W'(SLOTS - 1)) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    w_load    = 1'b1;
                    w_ld_last = !r_flush;
                    n_state   = r_flush ? S_CHECK : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_locked     <= '0;
            r_last_key   <= '0;
            r_emitted    <= 1'b0;
            r_fill       <= '0;
            r_free       <= '0;
            r_tape       <= '0;
            r_tape_count <= TAPE_COUNT_RESET;
            r_flush      <= 1'b0;
            r_rd_addr    <= '0;
            r_rd_vld     <= 1'b0;
            r_best_found <= 1'b0;
            r_best_idx   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == S_SCAN);

            if (i_cfg_valid) begin
                r_tape_count <= i_cfg_data;
            end

            if (r_state == S_IDLE && w_in_acc) begin
                r_flush <= w_in_flush;
                if (!w_in_flush) begin
                    r_valid[w_ins_slot]  <= 1'b1;
                    r_locked[w_ins_slot] <= r_emitted && (w_in_key < r_last_key);
                    if (w_filling) begin
                        r_fill <= w_fill_inc;
                    end
                end
            end

            if (r_state == S_CHECK) begin
                r_rd_addr    <= '0;
                r_best_found <= 1'b0;
                if (w_out_free && w_all_locked) begin
                    r_locked <= '0;
                    r_tape   <= w_next_tape;
                end
                if (w_out_free && r_valid == '0) begin
                    r_fill     <= '0;
                    r_free     <= '0;
                    r_emitted  <= 1'b0;
                    r_last_key <= '0;
                end
            end

            if (r_state == S_SCAN) begin
                r_rd_addr <= r_rd_addr + 1'b1;
            end

            if (w_cand) begin
                r_best_found <= 1'b1;
                r_best_idx   <= r_rd_idx;
            end

            if (r_state == S_EMIT && w_out_free) begin
                r_last_key           <= r_best_key;
                r_emitted            <= 1'b1;
                r_valid[r_best_idx]  <= 1'b0;
                r_locked[r_best_idx] <= 1'b0;
                r_free               <= r_best_idx;
            end

            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Slot memory: written only on an accepted insert, its read data used only while scanning, which
    // starts after the run check state, so a read never meets a write to the same entry.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_in_acc && !w_in_flush) begin
            r_mem[w_ins_slot] <= {w_in_pay, w_in_key};
        end
        r_rd_data <= r_mem[r_rd_addr];
        r_rd_idx  <= r_rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (w_cand) begin
            r_best_key <= r_rd_data[KEY_W-1:0];
            r_best_pay <= r_rd_data[REC_W-1:KEY_W];
        end
        if (w_load) begin
            r_out_key     <= w_ld_mark ? '0 : r_best_key;
            r_out_pay     <= w_ld_mark ? '0 : r_best_pay;
            r_out_tape    <= r_tape;
            r_out_run_end <= w_ld_mark;
            r_out_last    <= w_ld_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_tape, r_out_pay, r_out_key};
    assign m_axis_tuser  = r_out_run_end;
    assign m_axis_tlast  = r_out_last;

    `RSR_ASSERT_ALWAYS(a_lock_in_valid, i_clk, i_rst_n, (r_locked & ~r_valid) == '0, "locked slot is not occupied")
    `RSR_ASSERT_ALWAYS(a_fill_bound, i_clk, i_rst_n, r_fill <= FILL_W'(SLOTS), "fill count beyond slot count")
    `RSR_ASSERT_IMPLY(a_emit_found, i_clk, i_rst_n, r_state == S_EMIT, r_best_found, "emission without a candidate")
    `RSR_ASSERT_IMPLY(a_one_free, i_clk, i_rst_n, r_state == S_IDLE && r_fill == FILL_W'(SLOTS), ($countones(r_valid) == SLOTS - 1) && !r_valid[r_free], "full store does not have exactly one free slot")
    `RSR_ASSERT_NEXT(a_flush_check, i_clk, i_rst_n, w_in_acc && w_in_flush, r_state == S_CHECK, "flush transfer did not start a drain")

endmodule
